/* rtl/cdod_pkg.sv */
// ----------------------------------------------------------------------------
// cdod_pkg
// Types, widths, constants and calendar tables of the date offset and
// distance block.
// ----------------------------------------------------------------------------
package cdod_pkg;

    localparam int YEAR_W  = 14;
    localparam int MON_W   = 4;
    localparam int DAY_W   = 5;
    localparam int OFF_W   = 17;
    localparam int DIST_W  = 22;
    localparam int DN_W    = 23;
    localparam int WY_W    = 17;
    localparam int C400_W  = 9;
    localparam int Q_W     = 8;
    localparam int R_W     = 7;
    localparam int PROD_W  = 2 * YEAR_W;
    localparam int CUM_W   = 9;

    // floor(2^20 / 100), quotient estimate is low by at most one
    localparam int RECIP_SH = 20;
    localparam logic [YEAR_W-1:0] RECIP = YEAR_W'(10485);

    localparam logic [MON_W-1:0] MON_JAN = MON_W'(1);
    localparam logic [MON_W-1:0] MON_FEB = MON_W'(2);
    localparam logic [MON_W-1:0] MON_DEC = MON_W'(12);
    localparam logic [DAY_W-1:0] DAY_DEC_LAST = DAY_W'(31);

    localparam logic [WY_W-1:0]   DEF_YEAR  = WY_W'(1900);
    localparam logic [DN_W-1:0]   DN_1900   = DN_W'(693961);
    localparam logic [C400_W-1:0] C400_1900 = C400_W'(300);
    localparam logic [C400_W-1:0] C400_LAST = C400_W'(399);
    localparam logic [DIST_W-1:0] DIST_MAX  = '1;

    typedef struct packed {
        logic                    operation;
        logic [YEAR_W-1:0]       year;
        logic [MON_W-1:0]        month;
        logic [DAY_W-1:0]        day;
        logic signed [OFF_W-1:0] day_offset;
        logic [YEAR_W-1:0]       other_year;
        logic [MON_W-1:0]        other_month;
        logic [DAY_W-1:0]        other_day;
    } t_in_item;

    typedef struct packed {
        logic [YEAR_W-1:0] result_year;
        logic [MON_W-1:0]  result_month;
        logic [DAY_W-1:0]  result_day;
        logic [DIST_W-1:0] day_distance;
        logic              input_invalid;
        logic              out_of_range;
    } t_out_item;

    typedef struct packed {
        logic capture;
        logic mul;
        logic div;
        logic ys;
        logic dn;
        logic sel_other;
        logic walk;
        logic diff;
        logic out_load;
    } t_cmd;

    typedef struct packed {
        logic op;
        logic walk_fin;
    } t_sts;

    function automatic logic [DAY_W-1:0] days_in_month(input logic [MON_W-1:0] m,
                                                       input logic leap);
        logic [DAY_W-1:0] n;
        case (m)
            4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: n = DAY_W'(31);
            4'd4, 4'd6, 4'd9, 4'd11:                    n = DAY_W'(30);
            4'd2:                                       n = leap ? DAY_W'(29) : DAY_W'(28);
            default:                                    n = '0;
        endcase
        return n;
    endfunction

    // days before the first of month m in a common year
    function automatic logic [CUM_W-1:0] cum_days(input logic [MON_W-1:0] m);
        logic [CUM_W-1:0] n;
        case (m)
            4'd2:    n = CUM_W'(31);
            4'd3:    n = CUM_W'(59);
            4'd4:    n = CUM_W'(90);
            4'd5:    n = CUM_W'(120);
            4'd6:    n = CUM_W'(151);
            4'd7:    n = CUM_W'(181);
            4'd8:    n = CUM_W'(212);
            4'd9:    n = CUM_W'(243);
            4'd10:   n = CUM_W'(273);
            4'd11:   n = CUM_W'(304);
            4'd12:   n = CUM_W'(334);
            default: n = '0;
        endcase
        return n;
    endfunction

endpackage

/* rtl/cdod_in_if.sv */
// ----------------------------------------------------------------------------
// cdod_in_if
// Request channel: valid/ready handshake with the date and offset payload.
// ----------------------------------------------------------------------------
interface cdod_in_if import cdod_pkg::*; ();
    logic                    valid;
    logic                    ready;
    logic                    operation;
    logic [YEAR_W-1:0]       year;
    logic [MON_W-1:0]        month;
    logic [DAY_W-1:0]        day;
    logic signed [OFF_W-1:0] day_offset;
    logic [YEAR_W-1:0]       other_year;
    logic [MON_W-1:0]        other_month;
    logic [DAY_W-1:0]        other_day;

    modport source (
        output valid, operation, year, month, day, day_offset,
               other_year, other_month, other_day,
        input  ready
    );

    modport sink (
        input  valid, operation, year, month, day, day_offset,
               other_year, other_month, other_day,
        output ready
    );
endinterface

/* rtl/cdod_out_if.sv */
// ----------------------------------------------------------------------------
// cdod_out_if
// Result channel: valid/ready handshake with the date and distance payload.
// ----------------------------------------------------------------------------
interface cdod_out_if import cdod_pkg::*; ();
    logic              valid;
    logic              ready;
    logic [YEAR_W-1:0] result_year;
    logic [MON_W-1:0]  result_month;
    logic [DAY_W-1:0]  result_day;
    logic [DIST_W-1:0] day_distance;
    logic              input_invalid;
    logic              out_of_range;

    modport source (
        output valid, result_year, result_month, result_day, day_distance,
               input_invalid, out_of_range,
        input  ready
    );

    modport sink (
        input  valid, result_year, result_month, result_day, day_distance,
               input_invalid, out_of_range,
        output ready
    );
endinterface

/* rtl/calendar_date_offset_and_distance.sv */
// ----------------------------------------------------------------------------
// calendar_date_offset_and_distance: Gregorian date shift and day distance
// Shift: capture, year split, date check and day number, then the month walk, a boundary per step.
// Distance: year split and day number run once per date on one shared unit, then the difference.
// One item in flight; the next is taken in idle, which follows the load of the output register.
// Synchronous active-low reset clears the sequencer and the result valid; no memories.
// ----------------------------------------------------------------------------
module calendar_date_offset_and_distance import cdod_pkg::*; #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic              i_clk,
    input  logic              i_rst_n,
    cdod_in_if.sink           i_in,
    cdod_out_if.source        o_res
);

    t_cmd      cmd;
    t_sts      sts;
    t_in_item  in_item;
    t_out_item out_item;

    assign in_item.operation   = i_in.operation;
    assign in_item.year        = i_in.year;
    assign in_item.month       = i_in.month;
    assign in_item.day         = i_in.day;
    assign in_item.day_offset  = i_in.day_offset;
    assign in_item.other_year  = i_in.other_year;
    assign in_item.other_month = i_in.other_month;
    assign in_item.other_day   = i_in.other_day;

    cdod_ctrl u_ctrl (
        .i_clk       (i_clk),
        .i_rst_n     (i_rst_n),
        .i_in_valid  (i_in.valid),
        .o_in_ready  (i_in.ready),
        .o_out_valid (o_res.valid),
        .i_out_ready (o_res.ready),
        .o_cmd       (cmd),
        .i_sts       (sts)
    );

    cdod_dp #(
        .YEAR_MAX (YEAR_MAX)
    ) u_dp (
        .i_clk  (i_clk),
        .i_cmd  (cmd),
        .o_sts  (sts),
        .i_item (in_item),
        .o_item (out_item)
    );

    assign o_res.result_year   = out_item.result_year;
    assign o_res.result_month  = out_item.result_month;
    assign o_res.result_day    = out_item.result_day;
    assign o_res.day_distance  = out_item.day_distance;
    assign o_res.input_invalid = out_item.input_invalid;
    assign o_res.out_of_range  = out_item.out_of_range;

`ifndef SYNTHESIS
    a_one_item: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_in.valid && i_in.ready) |=> !i_in.ready)
        else $error("new transfer taken while an item is in flight");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        cmd.out_load |-> (!o_res.valid || o_res.ready))
        else $error("result register overwritten before its transfer");

    a_month: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_res.valid |-> (o_res.result_month >= MON_JAN && o_res.result_month <= MON_DEC))
        else $error("result month outside 1 to 12");

    a_dist_oor: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (o_res.valid && o_res.day_distance != '0) |-> !o_res.out_of_range)
        else $error("distance result flagged out of range");
`endif

endmodule

/* rtl/cdod_ctrl.sv */
// ----------------------------------------------------------------------------
// cdod_ctrl
// Sequencer: steps the datapath through year split, date check, day number,
// month walk or distance, and owns both handshakes.
// ----------------------------------------------------------------------------
module cdod_ctrl import cdod_pkg::*; (
    input  logic i_clk,
    input  logic i_rst_n,
    input  logic i_in_valid,
    output logic o_in_ready,
    output logic o_out_valid,
    input  logic i_out_ready,
    output t_cmd o_cmd,
    input  t_sts i_sts
);

    typedef enum logic [7:0] {
        S_IDLE = 8'b0000_0001,
        S_MUL  = 8'b0000_0010,
        S_DIV  = 8'b0000_0100,
        S_YS   = 8'b0000_1000,
        S_DN   = 8'b0001_0000,
        S_WALK = 8'b0010_0000,
        S_DIFF = 8'b0100_0000,
        S_DONE = 8'b1000_0000
    } t_state;

    t_state r_state, n_state;
    logic   r_second, n_second;
    logic   r_out_valid, n_out_valid;
    logic   out_free;

    assign out_free    = !r_out_valid || i_out_ready;
    assign o_in_ready  = (r_state == S_IDLE);
    assign o_out_valid = r_out_valid;

    always_comb begin
        n_state     = r_state;
        n_second    = r_second;
        o_cmd       = '0;
        o_cmd.sel_other = r_second;
        n_out_valid = r_out_valid && !i_out_ready;
        unique case (r_state)
            S_IDLE: begin
                if (i_in_valid) begin
                    o_cmd.capture = 1'b1;
                    n_second      = 1'b0;
                    n_state       = S_MUL;
                end
            end
            S_MUL: begin
                o_cmd.mul = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                o_cmd.div = 1'b1;
                n_state   = S_YS;
            end
            S_YS: begin
                o_cmd.ys = 1'b1;
                n_state  = S_DN;
            end
            S_DN: begin
                o_cmd.dn = 1'b1;
                if (r_second) begin
                    n_state = S_DIFF;
                end else if (i_sts.op) begin
                    n_second = 1'b1;
                    n_state  = S_MUL;
                end else begin
                    n_state = S_WALK;
                end
            end
            S_WALK: begin
                o_cmd.walk = 1'b1;
                if (i_sts.walk_fin) begin
                    n_state = S_DONE;
                end
            end
            S_DIFF: begin
                o_cmd.diff = 1'b1;
                n_state    = S_DONE;
            end
            S_DONE: begin
                if (out_free) begin
                    o_cmd.out_load = 1'b1;
                    n_out_valid    = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state     <= S_IDLE;
            r_second    <= 1'b0;
            r_out_valid <= 1'b0;
        end else begin
            r_state     <= n_state;
            r_second    <= n_second;
            r_out_valid <= n_out_valid;
        end
    end

endmodule

/* rtl/cdod_dp.sv */
// ----------------------------------------------------------------------------
// cdod_dp
// Datapath: year split by 100, date check, day numbers, month-by-month walk,
// distance and the result register.
// ----------------------------------------------------------------------------
module cdod_dp import cdod_pkg::*; #(
    parameter int unsigned YEAR_MAX = 9999
) (
    input  logic      i_clk,
    input  t_cmd      i_cmd,
    output t_sts      o_sts,
    input  t_in_item  i_item,
    output t_out_item o_item
);

    localparam logic [WY_W-1:0] YMAX = WY_W'(YEAR_MAX);

    // captured item
    logic                    r_op;
    logic [YEAR_W-1:0]       r_yi, r_oy;
    logic [MON_W-1:0]        r_mi, r_om;
    logic [DAY_W-1:0]        r_di, r_od;
    logic signed [OFF_W-1:0] r_off;

    // year split and day number
    logic [PROD_W-1:0] r_prod;
    logic [Q_W-1:0]    r_q;
    logic [R_W-1:0]    r_r;
    logic [DN_W-1:0]   r_ys;
    logic              r_valid;
    logic              r_leap;
    logic [DN_W-1:0]   r_dn_a, r_dn_b;

    // walk and result
    logic [WY_W-1:0]   r_y;
    logic [MON_W-1:0]  r_m;
    logic [DAY_W-1:0]  r_d;
    logic [OFF_W-1:0]  r_rem;
    logic              r_back;
    logic [C400_W-1:0] r_c400;
    logic [DIST_W-1:0] r_dist;
    logic              r_inv;
    logic              r_oor;
    t_out_item         r_out;

    logic [YEAR_W-1:0] x_y;
    logic [MON_W-1:0]  x_m;
    logic [DAY_W-1:0]  x_d;

    assign x_y = i_cmd.sel_other ? r_oy : r_yi;
    assign x_m = i_cmd.sel_other ? r_om : r_mi;
    assign x_d = i_cmd.sel_other ? r_od : r_di;

    // quotient correction
    logic [Q_W-1:0]    q_est;
    logic [YEAR_W:0]   r_est;
    logic              q_fix;

    assign q_est = r_prod[RECIP_SH +: Q_W];
    assign r_est = {1'b0, x_y} - ((YEAR_W+1)'(q_est) * (YEAR_W+1)'(100));
    assign q_fix = (r_est >= (YEAR_W+1)'(100));

    // year start and date check
    logic              leap_x;
    logic [Q_W:0]      q1;
    logic [DN_W-1:0]   ys_x;
    logic [DAY_W-1:0]  dim_x;
    logic              valid_x;

    always_comb begin
        leap_x  = (r_r != '0) ? (x_y[1:0] == 2'b00) : (r_q[1:0] == 2'b00);
        q1      = (Q_W+1)'(r_q) + (Q_W+1)'(r_r != '0);
        ys_x    = DN_W'(x_y) * DN_W'(365)
                + DN_W'(((YEAR_W+1)'(x_y) + (YEAR_W+1)'(3)) >> 2)
                - DN_W'(q1)
                + DN_W'(((Q_W+2)'(q1) + (Q_W+2)'(3)) >> 2);
        dim_x   = days_in_month(x_m, leap_x);
        valid_x = (WY_W'(x_y) <= YMAX) && (x_d != '0) && (x_d <= dim_x);
    end

    logic [DN_W-1:0] dn_x;

    assign dn_x = r_valid
                ? r_ys + DN_W'(cum_days(x_m))
                  + DN_W'(r_leap && (x_m > MON_FEB)) + DN_W'(x_d) - DN_W'(1)
                : DN_1900;

    // month walk step
    logic              leap_c;
    logic [DAY_W-1:0]  dim_c, dim_prev, space;
    logic [MON_W-1:0]  prev_m;
    logic              walk_fin, clamp_hi, clamp_lo;
    logic [WY_W-1:0]   w_y;
    logic [MON_W-1:0]  w_m;
    logic [DAY_W-1:0]  w_d;
    logic [OFF_W-1:0]  w_rem;
    logic [C400_W-1:0] w_c400;

    always_comb begin
        leap_c   = (r_c400[1:0] == 2'b00) && (r_c400 != C400_W'(100))
                && (r_c400 != C400_W'(200)) && (r_c400 != C400_W'(300));
        dim_c    = days_in_month(r_m, leap_c);
        prev_m   = r_m - MON_W'(1);
        dim_prev = days_in_month(prev_m, leap_c);
        space    = dim_c - r_d;
        walk_fin = 1'b0;
        clamp_hi = 1'b0;
        clamp_lo = 1'b0;
        w_y      = r_y;
        w_m      = r_m;
        w_d      = r_d;
        w_rem    = r_rem;
        w_c400   = r_c400;
        if (!r_back) begin
            if (r_rem <= OFF_W'(space)) begin
                walk_fin = 1'b1;
                w_d      = r_d + r_rem[DAY_W-1:0];
            end else begin
                w_rem = r_rem - OFF_W'(space) - OFF_W'(1);
                w_d   = DAY_W'(1);
                if (r_m == MON_DEC) begin
                    if (r_y >= YMAX) begin
                        walk_fin = 1'b1;
                        clamp_hi = 1'b1;
                    end else begin
                        w_y    = r_y + WY_W'(1);
                        w_m    = MON_JAN;
                        w_c400 = (r_c400 == C400_LAST) ? '0 : r_c400 + C400_W'(1);
                    end
                end else begin
                    w_m = r_m + MON_W'(1);
                end
            end
        end else begin
            if (r_rem < OFF_W'(r_d)) begin
                walk_fin = 1'b1;
                w_d      = r_d - r_rem[DAY_W-1:0];
            end else begin
                w_rem = r_rem - OFF_W'(r_d);
                if (r_m == MON_JAN) begin
                    if (r_y == '0) begin
                        walk_fin = 1'b1;
                        clamp_lo = 1'b1;
                    end else begin
                        w_y    = r_y - WY_W'(1);
                        w_m    = MON_DEC;
                        w_d    = DAY_DEC_LAST;
                        w_c400 = (r_c400 == '0) ? C400_LAST : r_c400 - C400_W'(1);
                    end
                end else begin
                    w_m = prev_m;
                    w_d = dim_prev;
                end
            end
        end
        if (walk_fin && !clamp_lo && (r_y > YMAX)) begin
            clamp_hi = 1'b1;
        end
        if (clamp_hi) begin
            w_y = YMAX;
            w_m = MON_DEC;
            w_d = DAY_DEC_LAST;
        end
        if (clamp_lo) begin
            w_y = '0;
            w_m = MON_JAN;
            w_d = DAY_W'(1);
        end
    end

    assign o_sts.op       = r_op;
    assign o_sts.walk_fin = walk_fin;

    // distance
    logic [DN_W-1:0] diff;

    assign diff = (r_dn_a > r_dn_b) ? r_dn_a - r_dn_b : r_dn_b - r_dn_a;

    always_ff @(posedge i_clk) begin
        if (i_cmd.capture) begin
            r_op  <= i_item.operation;
            r_yi  <= i_item.year;
            r_mi  <= i_item.month;
            r_di  <= i_item.day;
            r_off <= i_item.day_offset;
            r_oy  <= i_item.other_year;
            r_om  <= i_item.other_month;
            r_od  <= i_item.other_day;
        end
        if (i_cmd.mul) begin
            r_prod <= PROD_W'(x_y) * PROD_W'(RECIP);
        end
        if (i_cmd.div) begin
            r_q <= q_fix ? q_est + Q_W'(1) : q_est;
            r_r <= q_fix ? R_W'(r_est - (YEAR_W+1)'(100)) : R_W'(r_est);
        end
        if (i_cmd.ys) begin
            r_ys    <= ys_x;
            r_valid <= valid_x;
            r_leap  <= leap_x;
        end
        if (i_cmd.dn) begin
            if (!i_cmd.sel_other) begin
                r_dn_a <= dn_x;
                r_inv  <= !r_valid;
                r_oor  <= 1'b0;
                r_dist <= '0;
                r_back <= r_off[OFF_W-1];
                r_rem  <= r_off[OFF_W-1] ? OFF_W'(-r_off) : OFF_W'(r_off);
                if (r_valid) begin
                    r_y    <= WY_W'(r_yi);
                    r_m    <= r_mi;
                    r_d    <= r_di;
                    r_c400 <= C400_W'(r_q[1:0]) * C400_W'(100) + C400_W'(r_r);
                end else begin
                    r_y    <= DEF_YEAR;
                    r_m    <= MON_JAN;
                    r_d    <= DAY_W'(1);
                    r_c400 <= C400_1900;
                end
            end else begin
                r_dn_b <= dn_x;
                r_inv  <= r_inv || !r_valid;
            end
        end
        if (i_cmd.walk) begin
            r_y    <= w_y;
            r_m    <= w_m;
            r_d    <= w_d;
            r_rem  <= w_rem;
            r_c400 <= w_c400;
            r_oor  <= clamp_hi || clamp_lo;
        end
        if (i_cmd.diff) begin
            r_dist <= (diff > DN_W'(DIST_MAX)) ? DIST_MAX : DIST_W'(diff);
        end
        if (i_cmd.out_load) begin
            r_out.result_year   <= r_y[YEAR_W-1:0];
            r_out.result_month  <= r_m;
            r_out.result_day    <= r_d;
            r_out.day_distance  <= r_dist;
            r_out.input_invalid <= r_inv;
            r_out.out_of_range  <= r_oor;
        end
    end

    assign o_item = r_out;

endmodule
